// ===== design/jsop_pkg.sv =====
// Shared types and constants of the job stream option parser.
// No dependencies; imported by the parser core and the testbench files.
`default_nettype none
package jsop_pkg;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_WAIT_ESC,
    ST_BODY,
    ST_BODY_ESC,
    ST_HEADER,
    ST_ID,
    ST_PAYLOAD,
    ST_FLUSH
  } state_t;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_END   = 3'd1,
    KIND_PAGE  = 3'd2,
    KIND_VALUE = 3'd3,
    KIND_EMPTY = 3'd4,
    KIND_ERROR = 3'd5
  } kind_t;

  localparam logic [7:0] BYTE_SEP_LEAD = 8'h1e;
  localparam logic [7:0] BYTE_SEP_JOB  = 8'h52;
  localparam logic [7:0] BYTE_SEP_OPT  = 8'h26;
  localparam logic [7:0] BYTE_PAGE     = 8'h0c;
  localparam logic [7:0] BYTE_DIGIT_0  = 8'h30;
  localparam logic [7:0] BYTE_DIGIT_9  = 8'h39;

  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 8;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VARLEN_A = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VARLEN_B = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_VARLEN_C = 2'd2;

  localparam logic [7:0] VARLEN_A_RST = 8'd105;
  localparam logic [7:0] VARLEN_B_RST = 8'd101;
  localparam logic [7:0] VARLEN_C_RST = 8'd110;

endpackage
`default_nettype wire

// ===== design/jsop_in_if.sv =====
// Input byte channel: valid/ready handshake carrying one stream byte.
// No dependencies.
`default_nettype none
interface jsop_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ===== design/jsop_out_if.sv =====
// Result channel: valid/ready handshake carrying one parser result.
// No dependencies.
`default_nettype none
interface jsop_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] option_id;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output kind, output option_id, output data_byte,
                  output last, input ready);
  modport sink   (input valid, input kind, input option_id, input data_byte,
                  input last, output ready);
endinterface
`default_nettype wire

// ===== design/jsop_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module jsop_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== design/job_stream_option_parser_core.sv =====
// Top level of the job stream option parser: state machine, length decode,
// header memory (jsop_ram) and output register. Uses jsop_pkg, jsop_in_if, jsop_out_if.
`default_nettype none
// The parser takes one stream byte per request and gives at most one result per
// byte, except for the id byte of a fixed-value option, which replays the
// buffered header as one value byte per header byte. A byte is taken whenever
// the output register is free or being emptied, except during the replay. The
// replay reads the header memory one entry at a time, a read then an output of
// that entry, and holds the input until the last buffered header byte is given
// out. The header memory needs no clearing after reset; only entries written in
// the current option are ever read.
module job_stream_option_parser_core
  import jsop_pkg::*;
#(
  parameter int unsigned HEADER_DEPTH = 16,
  parameter int unsigned LENGTH_BITS  = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
  jsop_in_if.sink                        in_ch,
  jsop_out_if.source                     out_ch
);

  localparam int unsigned AW = $clog2(HEADER_DEPTH);
  localparam int unsigned CW = $clog2(HEADER_DEPTH + 1);
  localparam int unsigned NW = LENGTH_BITS + 4;
  localparam logic [CW-1:0] COUNT_FULL = CW'(HEADER_DEPTH);

  state_t state, state_next;

  logic [7:0] varlen_a, varlen_b, varlen_c;

  logic [CW-1:0]          hdr_count, hdr_count_next;
  logic [LENGTH_BITS-1:0] len_value, len_value_next;
  logic                   digits_ended, digits_ended_next;
  logic [LENGTH_BITS-1:0] payload_left, payload_left_next;
  logic [7:0]             current_id, current_id_next;
  logic [CW-1:0]          rd_idx, rd_idx_next;
  logic                   rd_pend, rd_pend_next;

  logic       out_valid;
  kind_t      out_kind;
  logic [7:0] out_id, out_data;
  logic       out_last;

  logic       res_load;
  kind_t      res_kind;
  logic [7:0] res_id, res_data;
  logic       res_last;

  logic             wr_en, rd_en;
  logic [7:0]       rd_data;
  logic [7:0]       b;
  logic             in_acc, out_free, flush_take, flush_last;
  logic             is_varlen, hdr_full, is_digit;
  logic [3:0]       digit;
  logic [NW-1:0]    len_mul;
  logic [LENGTH_BITS-1:0] len_sat;
  logic [LENGTH_BITS-1:0] payload_dec;
  logic [CW-1:0]    rd_idx_inc;

  assign b          = in_ch.in_byte;
  assign out_free   = !out_valid || out_ch.ready;
  assign in_ch.ready = (state != ST_FLUSH) && out_free;
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign flush_take = (state == ST_FLUSH) && rd_pend && out_free;
  assign rd_idx_inc = rd_idx + 1'b1;
  assign flush_last = (rd_idx_inc == hdr_count);

  assign is_varlen = (b == varlen_a) || (b == varlen_b) || (b == varlen_c);
  assign hdr_full  = (hdr_count >= COUNT_FULL);
  assign is_digit  = (b >= BYTE_DIGIT_0) && (b <= BYTE_DIGIT_9);
  assign digit     = 4'(b - BYTE_DIGIT_0);
  assign len_mul   = NW'({len_value, 3'b000}) + NW'({len_value, 1'b0}) + NW'(digit);
  assign len_sat   = (|len_mul[NW-1:LENGTH_BITS]) ? {LENGTH_BITS{1'b1}}
                                                  : len_mul[LENGTH_BITS-1:0];
  assign payload_dec = payload_left - 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_WAIT: begin
        if (in_acc && b == BYTE_SEP_LEAD) state_next = ST_WAIT_ESC;
      end
      ST_WAIT_ESC: begin
        if (in_acc) begin
          if (b == BYTE_SEP_JOB) state_next = ST_BODY;
          else if (b != BYTE_SEP_LEAD) state_next = ST_WAIT;
        end
      end
      ST_BODY: begin
        if (in_acc && b == BYTE_SEP_LEAD) state_next = ST_BODY_ESC;
      end
      ST_BODY_ESC: begin
        if (in_acc) begin
          if (b == BYTE_SEP_JOB) state_next = ST_WAIT;
          else if (b == BYTE_SEP_OPT) state_next = ST_HEADER;
          else state_next = ST_BODY;
        end
      end
      ST_HEADER: begin
        if (in_acc) begin
          if (b == BYTE_SEP_OPT) state_next = ST_ID;
          else if (hdr_full) state_next = ST_BODY;
        end
      end
      ST_ID: begin
        if (in_acc) begin
          if (is_varlen) state_next = (len_value == '0) ? ST_BODY : ST_PAYLOAD;
          else state_next = (hdr_count == '0) ? ST_BODY : ST_FLUSH;
        end
      end
      ST_PAYLOAD: begin
        if (in_acc && payload_dec == '0) state_next = ST_BODY;
      end
      ST_FLUSH: begin
        if (flush_take && flush_last) state_next = ST_BODY;
      end
      default: state_next = ST_WAIT;
    endcase
  end

  // datapath and results
  always_comb begin
    hdr_count_next    = hdr_count;
    len_value_next    = len_value;
    digits_ended_next = digits_ended;
    payload_left_next = payload_left;
    current_id_next   = current_id;
    rd_idx_next       = rd_idx;
    rd_pend_next      = rd_pend;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    res_load = 1'b0;
    res_kind = KIND_ERROR;
    res_id   = '0;
    res_data = '0;
    res_last = 1'b0;
    case (state)
      ST_WAIT_ESC: begin
        if (in_acc && b == BYTE_SEP_JOB) begin
          res_load = 1'b1;
          res_kind = KIND_START;
        end
      end
      ST_BODY: begin
        if (in_acc) begin
          if (b == BYTE_PAGE) begin
            res_load = 1'b1;
            res_kind = KIND_PAGE;
          end else if (b != BYTE_SEP_LEAD) begin
            res_load = 1'b1;
            res_data = b;
          end
        end
      end
      ST_BODY_ESC: begin
        if (in_acc) begin
          if (b == BYTE_SEP_JOB) begin
            res_load = 1'b1;
            res_kind = KIND_END;
          end else if (b == BYTE_SEP_OPT) begin
            hdr_count_next    = '0;
            len_value_next    = '0;
            digits_ended_next = 1'b0;
          end else begin
            res_load = 1'b1;
            res_data = b;
          end
        end
      end
      ST_HEADER: begin
        if (in_acc && b != BYTE_SEP_OPT) begin
          if (hdr_full) begin
            res_load = 1'b1;
            res_data = b;
          end else begin
            wr_en          = 1'b1;
            hdr_count_next = hdr_count + 1'b1;
            if (!digits_ended && is_digit) len_value_next = len_sat;
            else digits_ended_next = 1'b1;
          end
        end
      end
      ST_ID: begin
        if (in_acc) begin
          current_id_next = b;
          rd_idx_next     = '0;
          rd_pend_next    = 1'b0;
          if (is_varlen) payload_left_next = len_value;
          if ((is_varlen && len_value == '0) || (!is_varlen && hdr_count == '0)) begin
            res_load = 1'b1;
            res_kind = KIND_EMPTY;
            res_id   = b;
            res_last = 1'b1;
          end
        end
      end
      ST_PAYLOAD: begin
        if (in_acc) begin
          payload_left_next = payload_dec;
          res_load = 1'b1;
          res_kind = KIND_VALUE;
          res_id   = current_id;
          res_data = b;
          res_last = (payload_dec == '0);
        end
      end
      ST_FLUSH: begin
        if (!rd_pend) begin
          rd_en        = 1'b1;
          rd_pend_next = 1'b1;
        end else if (flush_take) begin
          rd_pend_next = 1'b0;
          rd_idx_next  = rd_idx_inc;
          res_load = 1'b1;
          res_kind = KIND_VALUE;
          res_id   = current_id;
          res_data = rd_data;
          res_last = flush_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_WAIT;
      varlen_a     <= VARLEN_A_RST;
      varlen_b     <= VARLEN_B_RST;
      varlen_c     <= VARLEN_C_RST;
      hdr_count    <= '0;
      len_value    <= '0;
      digits_ended <= 1'b0;
      payload_left <= '0;
      current_id   <= '0;
      rd_idx       <= '0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      hdr_count    <= hdr_count_next;
      len_value    <= len_value_next;
      digits_ended <= digits_ended_next;
      payload_left <= payload_left_next;
      current_id   <= current_id_next;
      rd_idx       <= rd_idx_next;
      rd_pend      <= rd_pend_next;
      if (res_load) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_VARLEN_A: varlen_a <= cfg_data;
          CFG_VARLEN_B: varlen_b <= cfg_data;
          CFG_VARLEN_C: varlen_c <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_kind <= res_kind;
      out_id   <= res_id;
      out_data <= res_data;
      out_last <= res_last;
    end
  end

  jsop_ram #(
    .WIDTH (8),
    .DEPTH (HEADER_DEPTH)
  ) u_header_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (hdr_count[AW-1:0]),
    .wdata (b),
    .re    (rd_en),
    .raddr (rd_idx[AW-1:0]),
    .rdata (rd_data)
  );

  assign out_ch.valid     = out_valid;
  assign out_ch.kind      = out_kind;
  assign out_ch.option_id = out_id;
  assign out_ch.data_byte = out_data;
  assign out_ch.last      = out_last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    hdr_count <= COUNT_FULL)
    else $error("header count beyond depth");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_PAYLOAD |-> payload_left != '0)
    else $error("payload phase with nothing left");

  a_flush_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_FLUSH |-> (hdr_count != '0) && (rd_idx < hdr_count))
    else $error("replay index outside buffered header");

  a_flush_no_overrun: assert property (@(posedge clk) disable iff (rst)
    flush_take && flush_last |=> state == ST_BODY)
    else $error("replay did not end after last header byte");
`endif

endmodule
`default_nettype wire

// ===== test/jsop_event_checker.sv =====
`timescale 1ns / 100ps
// Checker for the job stream option parser: mirrors the parser state on every
// accepted request and compares each result. Depends on jsop_pkg.
module jsop_event_checker
  import jsop_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [7:0]                in_byte,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [2:0]                out_kind,
  input  logic [7:0]                out_option_id,
  input  logic [7:0]                out_data_byte,
  input  logic                      out_last,
  output int                        fail_count,
  output int                        outstanding
);

  localparam int unsigned HDR_DEPTH = 16;
  localparam int unsigned LEN_MAX   = 65535;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] option_id;
    logic [7:0] data_byte;
    logic       last;
  } parse_event_t;

  parse_event_t due_events[$];

  logic [7:0]  id_a, id_b, id_c;
  state_t      phase;
  logic [7:0]  hdr_mem[HDR_DEPTH];
  int unsigned hdr_count;
  int unsigned len_acc;
  bit          digits_done;
  int unsigned payload_left;
  logic [7:0]  cur_id;

  function automatic bit is_length_id(input logic [7:0] id);
    return id == id_a || id == id_b || id == id_c;
  endfunction

  task automatic emit(input kind_t k, input logic [7:0] id, input logic [7:0] data,
                      input logic lst);
    parse_event_t ev;
    ev.kind      = k;
    ev.option_id = id;
    ev.data_byte = data;
    ev.last      = lst;
    due_events.push_back(ev);
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int unsigned acc;
    case (phase)
      ST_WAIT: begin
        if (b == BYTE_SEP_LEAD) phase = ST_WAIT_ESC;
      end
      ST_WAIT_ESC: begin
        if (b == BYTE_SEP_JOB) begin
          emit(KIND_START, 8'h00, 8'h00, 1'b0);
          phase = ST_BODY;
        end else if (b != BYTE_SEP_LEAD) begin
          phase = ST_WAIT;
        end
      end
      ST_BODY: begin
        if (b == BYTE_PAGE) begin
          emit(KIND_PAGE, 8'h00, 8'h00, 1'b0);
        end else if (b == BYTE_SEP_LEAD) begin
          phase = ST_BODY_ESC;
        end else begin
          emit(KIND_ERROR, 8'h00, b, 1'b0);
        end
      end
      ST_BODY_ESC: begin
        if (b == BYTE_SEP_JOB) begin
          emit(KIND_END, 8'h00, 8'h00, 1'b0);
          phase = ST_WAIT;
        end else if (b == BYTE_SEP_OPT) begin
          hdr_count   = 0;
          len_acc     = 0;
          digits_done = 1'b0;
          phase       = ST_HEADER;
        end else begin
          emit(KIND_ERROR, 8'h00, b, 1'b0);
          phase = ST_BODY;
        end
      end
      ST_HEADER: begin
        if (b == BYTE_SEP_OPT) begin
          phase = ST_ID;
        end else if (hdr_count >= HDR_DEPTH) begin
          emit(KIND_ERROR, 8'h00, b, 1'b0);
          phase = ST_BODY;
        end else begin
          hdr_mem[hdr_count] = b;
          hdr_count++;
          if (!digits_done && b >= BYTE_DIGIT_0 && b <= BYTE_DIGIT_9) begin
            acc     = len_acc * 10 + (b - BYTE_DIGIT_0);
            len_acc = (acc > LEN_MAX) ? LEN_MAX : acc;
          end else begin
            digits_done = 1'b1;
          end
        end
      end
      ST_ID: begin
        cur_id = b;
        if (is_length_id(b)) begin
          payload_left = len_acc;
          if (payload_left == 0) begin
            emit(KIND_EMPTY, b, 8'h00, 1'b1);
            phase = ST_BODY;
          end else begin
            phase = ST_PAYLOAD;
          end
        end else begin
          if (hdr_count == 0) begin
            emit(KIND_EMPTY, b, 8'h00, 1'b1);
          end else begin
            for (int unsigned i = 0; i < hdr_count; i++) begin
              emit(KIND_VALUE, b, hdr_mem[i], i + 1 == hdr_count);
            end
          end
          phase = ST_BODY;
        end
      end
      ST_PAYLOAD: begin
        if (payload_left > 0) payload_left--;
        emit(KIND_VALUE, cur_id, b, payload_left == 0);
        if (payload_left == 0) phase = ST_BODY;
      end
      default: begin
        phase = ST_WAIT;
      end
    endcase
  endtask

  always @(posedge clk) begin
    parse_event_t want;
    if (rst) begin
      id_a         = VARLEN_A_RST;
      id_b         = VARLEN_B_RST;
      id_c         = VARLEN_C_RST;
      phase        = ST_WAIT;
      hdr_count    = 0;
      len_acc      = 0;
      digits_done  = 1'b0;
      payload_left = 0;
      cur_id       = 8'h00;
      due_events.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_VARLEN_A: id_a = cfg_data;
          CFG_VARLEN_B: id_b = cfg_data;
          CFG_VARLEN_C: id_c = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) parse_byte(in_byte);
      if (out_valid && out_ready) begin
        if (due_events.size() == 0) begin
          $display("%0t: unexpected result kind=%0d id=%02h data=%02h last=%0b", $time,
                   out_kind, out_option_id, out_data_byte, out_last);
          fail_count++;
        end else begin
          want = due_events.pop_front();
          if (out_kind !== want.kind || out_option_id !== want.option_id ||
              out_data_byte !== want.data_byte || out_last !== want.last) begin
            $display("%0t: mismatch expected kind=%0d id=%02h data=%02h last=%0b", $time,
                     want.kind, want.option_id, want.data_byte, want.last);
            $display("%0t:          actual   kind=%0d id=%02h data=%02h last=%0b", $time,
                     out_kind, out_option_id, out_data_byte, out_last);
            fail_count++;
          end
        end
      end
    end
    outstanding = due_events.size();
  end

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

endmodule

// ===== test/job_stream_option_parser_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for job_stream_option_parser_core: drives the byte stream, the
// config port and result backpressure. Depends on jsop_pkg, the channel
// interfaces and jsop_event_checker.
module job_stream_option_parser_core_tb;
  import jsop_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_BYTES  = 10;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int         fail_count;
  int         outstanding;
  int         cycles;
  int         sent;
  int         out_stall;
  bit         out_fire;
  bit         calm;
  logic [7:0] ids[3];

  jsop_in_if  in_ch();
  jsop_out_if out_ch();

  job_stream_option_parser_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  jsop_event_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_byte       (in_ch.in_byte),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_kind      (out_ch.kind),
    .out_option_id (out_ch.option_id),
    .out_data_byte (out_ch.data_byte),
    .out_last      (out_ch.last),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int idle_draw();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  // result backpressure: a fresh random stall, possibly none, after each accepted result
  always @(posedge clk) out_fire <= out_ch.valid && out_ch.ready;

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_fire) out_stall = idle_draw();
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one request per byte; called and returns at a falling edge
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    @(negedge clk);
    sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_ids(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    ids[0] = a;
    ids[1] = b;
    ids[2] = c;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VARLEN_A;
    cfg_data  <= a;
    @(negedge clk);
    cfg_index <= CFG_VARLEN_B;
    cfg_data  <= b;
    @(negedge clk);
    cfg_index <= CFG_VARLEN_C;
    cfg_data  <= c;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bit is_length_id(input logic [7:0] id);
    return id == ids[0] || id == ids[1] || id == ids[2];
  endfunction

  function automatic logic [7:0] header_byte(input bit no_digit);
    logic [7:0] b;
    do b = $urandom_range(0, 255);
    while (b == BYTE_SEP_OPT || (no_digit && b >= BYTE_DIGIT_0 && b <= BYTE_DIGIT_9));
    return b;
  endfunction

  task automatic send_fixed_option();
    int         hdr_len;
    logic [7:0] id;
    push_byte(BYTE_SEP_LEAD);
    push_byte(BYTE_SEP_OPT);
    case ($urandom_range(0, 9))
      0: hdr_len = 16;
      1: hdr_len = 17;
      2: hdr_len = 0;
      default: hdr_len = $urandom_range(1, 6);
    endcase
    repeat (hdr_len) push_byte(header_byte(1'b0));
    if (hdr_len <= 16) begin
      do id = $urandom_range(0, 255); while (is_length_id(id));
      push_byte(BYTE_SEP_OPT);
      push_byte(id);
    end
  endtask

  task automatic send_length_option();
    int    count;
    string txt;
    push_byte(BYTE_SEP_LEAD);
    push_byte(BYTE_SEP_OPT);
    case ($urandom_range(0, 7))
      0: begin
        count = 0;
        repeat ($urandom_range(0, 2)) push_byte(header_byte(1'b1));
      end
      1: begin
        count = $urandom_range(10, 40);
        txt   = $sformatf("0%0d", count);
      end
      default: begin
        count = $urandom_range(0, 9);
        txt   = $sformatf("%0d", count);
      end
    endcase
    for (int i = 0; i < txt.len(); i++) push_byte(txt[i]);
    if (txt.len() > 0 && $urandom_range(0, 3) == 0) begin
      push_byte(header_byte(1'b1));
      push_byte(BYTE_DIGIT_9);
    end
    push_byte(BYTE_SEP_OPT);
    push_byte(ids[$urandom_range(0, 2)]);
    repeat (count) push_byte($urandom_range(0, 255));
  endtask

  task automatic random_job();
    calm = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(0, 2)) push_byte($urandom_range(0, 255));
    if ($urandom_range(0, 7) != 0) begin
      push_byte(BYTE_SEP_LEAD);
      push_byte(BYTE_SEP_JOB);
    end
    repeat ($urandom_range(1, 5)) begin
      case ($urandom_range(0, 9))
        0: push_byte(BYTE_PAGE);
        1: push_byte($urandom_range(0, 255));
        2: begin
          push_byte(BYTE_SEP_LEAD);
          push_byte($urandom_range(0, 255));
        end
        3, 4, 5: send_fixed_option();
        default: send_length_option();
      endcase
    end
    if ($urandom_range(0, 7) != 0) begin
      push_byte(BYTE_SEP_LEAD);
      push_byte(BYTE_SEP_JOB);
    end
  endtask

  initial begin
    logic [7:0] opening[] = '{8'hff, BYTE_SEP_LEAD, BYTE_SEP_LEAD, BYTE_SEP_JOB,
                              BYTE_PAGE, 8'h00, BYTE_SEP_LEAD, 8'hff,
                              BYTE_SEP_LEAD, BYTE_SEP_OPT, BYTE_SEP_OPT, 8'h7a,
                              BYTE_SEP_LEAD, BYTE_SEP_OPT, BYTE_DIGIT_0, BYTE_SEP_OPT,
                              VARLEN_B_RST,
                              BYTE_SEP_LEAD, BYTE_SEP_OPT, 8'h31, BYTE_SEP_OPT,
                              VARLEN_A_RST, 8'h80,
                              BYTE_SEP_LEAD, BYTE_SEP_JOB};
    logic [7:0] ph_ids[4][3] = '{'{8'h00, 8'hff, 8'h80},
                                 '{8'hff, 8'h00, BYTE_DIGIT_0},
                                 '{8'h41, BYTE_SEP_OPT, BYTE_SEP_LEAD},
                                 '{VARLEN_A_RST, VARLEN_B_RST, VARLEN_C_RST}};
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    out_ch.ready  = 1'b0;
    out_stall     = 0;
    cycles        = 0;
    sent          = 0;
    calm          = 1'b0;
    ids[0]        = VARLEN_A_RST;
    ids[1]        = VARLEN_B_RST;
    ids[2]        = VARLEN_C_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (opening[i]) push_byte(opening[i]);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      set_ids(ph_ids[ph][0], ph_ids[ph][1], ph_ids[ph][2]);
      sent = 0;
      while (sent < PHASE_BYTES) random_job();
    end

    settle();
    if (fail_count == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
